// ===== hdl/deq_pkg.sv =====
// shared constants and codes for the double-ended queue
package deq_pkg;

  localparam int VALUE_W       = 32;
  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

endpackage

// ===== hdl/deq_mem.sv =====
// slot storage: one write port, one read port with registered read data
module deq_mem
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/double_ended_queue_unit.sv =====
// Double-ended queue of DEPTH signed 32-bit values in a ring buffer memory.
// Requests enter through a one-entry input register, so a request is taken
// while the previous result still waits on the output. Pushes, removals from
// an empty queue and removals that leave it empty load their result directly;
// a removal that leaves one or more values needs the new front or back value
// from the slot memory, whose read data is registered, so it passes through
// the read state first. The front and back values are kept in registers
// beside the memory, so each request does at most one memory access. A full
// queue drops pushes and reports full status.
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [VALUE_W-1:0]  s_tdata,   // value
  input  logic [1:0]          s_tuser,   // action
  output logic                m_tvalid,
  input  logic                m_tready,
  // removed_value, front_value, back_value, count, is_empty, zero fill
  output logic [((3*VALUE_W+$clog2(DEPTH+1)+1+7)/8)*8-1:0] m_tdata,
  output logic [1:0]          m_tuser    // status
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int DATA_W = 3 * VALUE_W + CW + 1;

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // input register
  logic               req_valid;
  action_t            req_action;
  logic [VALUE_W-1:0] req_value;

  // queue state
  state_t             state, state_next;
  logic [AW-1:0]      head, head_next;
  logic [AW-1:0]      tail, tail_next;
  logic [CW-1:0]      count, count_next;
  logic [VALUE_W-1:0] front_val, front_next;
  logic [VALUE_W-1:0] back_val, back_next;
  logic               rd_front;
  logic [VALUE_W-1:0] pend_removed;

  // output register
  status_t            o_status;
  logic [VALUE_W-1:0] o_removed;
  logic [VALUE_W-1:0] o_front;
  logic [VALUE_W-1:0] o_back;
  logic [CW-1:0]      o_count;

  logic               out_free;
  logic               req_take;
  logic               load;
  status_t            res_status;
  logic [VALUE_W-1:0] res_removed;
  logic               enter_read;
  logic               read_front;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  logic [AW-1:0]      head_inc, head_dec, tail_inc, tail_dec;
  logic               q_empty, q_full;

  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LAST_IDX : head - 1'b1;
  assign tail_inc = (tail == LAST_IDX) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? LAST_IDX : tail - 1'b1;
  assign q_empty  = (count == '0);
  assign q_full   = (count == FULL_CNT);

  assign out_free = !m_tvalid || m_tready;
  assign req_take = req_valid && (state == ST_IDLE) && out_free;
  assign s_tready = !req_valid || req_take;

  deq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (req_value),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    front_next  = front_val;
    back_next   = back_val;
    mem_we      = 1'b0;
    mem_waddr   = head_dec;
    mem_re      = 1'b0;
    mem_raddr   = head_inc;
    load        = 1'b0;
    enter_read  = 1'b0;
    read_front  = rd_front;
    res_status  = STS_OK;
    res_removed = '1;
    if (state == ST_READ) begin
      // new end value arrives from the memory
      state_next  = ST_IDLE;
      load        = 1'b1;
      res_removed = pend_removed;
      if (rd_front) begin
        front_next = mem_rdata;
      end else begin
        back_next = mem_rdata;
      end
    end else if (req_take) begin
      load = 1'b1;
      case (req_action)
        ACT_PUSH_FRONT: begin
          if (q_full) begin
            res_status = STS_FULL;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = head_dec;
            head_next  = head_dec;
            count_next = count + 1'b1;
            front_next = req_value;
            if (q_empty) begin
              back_next = req_value;
            end
          end
        end
        ACT_PUSH_BACK: begin
          if (q_full) begin
            res_status = STS_FULL;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = tail_inc;
            tail_next  = tail_inc;
            count_next = count + 1'b1;
            back_next  = req_value;
            if (q_empty) begin
              front_next = req_value;
            end
          end
        end
        ACT_POP_FRONT: begin
          if (q_empty) begin
            res_status = STS_EMPTY;
          end else begin
            res_removed = front_val;
            head_next   = head_inc;
            count_next  = count - 1'b1;
            if (count != CW'(1)) begin
              mem_re     = 1'b1;
              mem_raddr  = head_inc;
              load       = 1'b0;
              enter_read = 1'b1;
              read_front = 1'b1;
              state_next = ST_READ;
            end
          end
        end
        default: begin
          if (q_empty) begin
            res_status = STS_EMPTY;
          end else begin
            res_removed = back_val;
            tail_next   = tail_dec;
            count_next  = count - 1'b1;
            if (count != CW'(1)) begin
              mem_re     = 1'b1;
              mem_raddr  = tail_dec;
              load       = 1'b0;
              enter_read = 1'b1;
              read_front = 1'b0;
              state_next = ST_READ;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= LAST_IDX;
      count     <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        req_valid <= 1'b1;
      end else if (req_take) begin
        req_valid <= 1'b0;
      end
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_action <= action_t'(s_tuser);
      req_value  <= s_tdata;
    end
    front_val <= front_next;
    back_val  <= back_next;
    if (enter_read) begin
      rd_front     <= read_front;
      pend_removed <= res_removed;
    end
    if (load) begin
      o_status  <= res_status;
      o_removed <= res_removed;
      o_front   <= (count_next == '0) ? '1 : front_next;
      o_back    <= (count_next == '0) ? '1 : back_next;
      o_count   <= count_next;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[DATA_W-1:0] = {(o_count == '0), o_count, o_back, o_front, o_removed};
  end

  assign m_tuser = o_status;

  // the ring never holds more than its depth
  assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("stored count above depth");

  // an empty ring keeps the tail just behind the head
  assert property (@(posedge clk) disable iff (rst) (count == '0) |-> (tail == head_dec))
    else $error("head and tail out of step on empty queue");

  // the read state always returns straight to idle
  assert property (@(posedge clk) disable iff (rst) (state == ST_READ) |=> (state == ST_IDLE))
    else $error("read state held too long");

  // a read is only started once the output register will be free
  assert property (@(posedge clk) disable iff (rst) (state == ST_READ) |-> !m_tvalid)
    else $error("result pending while read completes");

endmodule

// ===== dv/tb.sv =====
// self-checking stream testbench for the double-ended queue unit
module tb
  import deq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int MT_W = ((3 * VALUE_W + CNT_W + 1 + 7) / 8) * 8;
  localparam logic [VALUE_W-1:0] ALL_ONES = '1;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 205;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   removed;
    logic [VALUE_W-1:0]   front;
    logic [VALUE_W-1:0]   back;
    logic [CNT_W-1:0]     count;
    logic                 empty;
  } deq_result_t;

  typedef struct packed {
    action_t              act;
    logic [VALUE_W-1:0]   val;
    logic [7:0]           reps;
    logic                 fixed;
    deq_result_t          res;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [VALUE_W-1:0] s_tdata = '0;  // value
  logic [1:0]        s_tuser = '0;   // action
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [MT_W-1:0]   m_tdata;        // removed_value, front_value, back_value, count,
                                     // is_empty, zero fill
  logic [1:0]        m_tuser;        // status

  // predictor state
  logic [VALUE_W-1:0] model_slots [DEPTH];
  int                 model_head = 0;
  int                 model_count = 0;

  deq_result_t pending_results[$];
  int          errors = 0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  dir_row_t dir_table [13] = '{
    '{ACT_POP_FRONT,  32'h0,        8'd1,  1'b1,
      '{STS_EMPTY, ALL_ONES, ALL_ONES, ALL_ONES, 5'd0, 1'b1}},
    '{ACT_POP_BACK,   32'h0,        8'd1,  1'b1,
      '{STS_EMPTY, ALL_ONES, ALL_ONES, ALL_ONES, 5'd0, 1'b1}},
    '{ACT_PUSH_BACK,  32'h7FFFFFFF, 8'd1,  1'b1,
      '{STS_OK, ALL_ONES, 32'h7FFFFFFF, 32'h7FFFFFFF, 5'd1, 1'b0}},
    // head wraps backwards from slot zero
    '{ACT_PUSH_FRONT, 32'h80000000, 8'd1,  1'b1,
      '{STS_OK, ALL_ONES, 32'h80000000, 32'h7FFFFFFF, 5'd2, 1'b0}},
    '{ACT_POP_BACK,   32'h0,        8'd1,  1'b0, '0},
    // queue empties, head wraps forward to slot zero
    '{ACT_POP_FRONT,  32'h0,        8'd1,  1'b0, '0},
    '{ACT_PUSH_FRONT, 32'h0,        8'd1,  1'b0, '0},
    '{ACT_PUSH_BACK,  32'hFFFFFFFF, 8'd1,  1'b0, '0},
    // fill up, then push into the full queue
    '{ACT_PUSH_BACK,  32'h00000100, 8'd14, 1'b0, '0},
    '{ACT_PUSH_FRONT, 32'h12345678, 8'd1,  1'b0, '0},
    '{ACT_PUSH_BACK,  32'h12345678, 8'd1,  1'b0, '0},
    '{ACT_POP_FRONT,  32'h0,        8'd1,  1'b0, '0},
    '{ACT_POP_BACK,   32'h0,        8'd1,  1'b0, '0}
  };

  double_ended_queue_unit #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int ring_pos(int k);
    return (model_head + k) % DEPTH;
  endfunction

  function automatic deq_result_t deque_predict(action_t act, logic [VALUE_W-1:0] val);
    deq_result_t r;
    r.status  = STS_OK;
    r.removed = ALL_ONES;
    case (act)
      ACT_PUSH_FRONT: begin
        if (model_count >= DEPTH) begin
          r.status = STS_FULL;
        end else begin
          model_head = (model_head + DEPTH - 1) % DEPTH;
          model_slots[model_head] = val;
          model_count++;
        end
      end
      ACT_PUSH_BACK: begin
        if (model_count >= DEPTH) begin
          r.status = STS_FULL;
        end else begin
          model_slots[ring_pos(model_count)] = val;
          model_count++;
        end
      end
      ACT_POP_FRONT: begin
        if (model_count == 0) begin
          r.status = STS_EMPTY;
        end else begin
          r.removed = model_slots[model_head];
          model_head = ring_pos(1);
          model_count--;
        end
      end
      default: begin
        if (model_count == 0) begin
          r.status = STS_EMPTY;
        end else begin
          r.removed = model_slots[ring_pos(model_count - 1)];
          model_count--;
        end
      end
    endcase
    if (model_count == 0) begin
      r.front = ALL_ONES;
      r.back  = ALL_ONES;
      r.empty = 1'b1;
    end else begin
      r.front = model_slots[model_head];
      r.back  = model_slots[ring_pos(model_count - 1)];
      r.empty = 1'b0;
    end
    r.count = CNT_W'(model_count);
    return r;
  endfunction

  // offer one request, wait for acceptance, then queue its expected result
  task automatic send_req(input action_t act, input logic [VALUE_W-1:0] val,
                          input logic fixed, input deq_result_t fixed_res);
    deq_result_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
    pred = deque_predict(act, val);
    pending_results.insert(pending_results.size(), fixed ? fixed_res : pred);
  endtask

  // receiver: random stalls plus a single long hold-off
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [VALUE_W-1:0] exp_v,
                             input logic [VALUE_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    deq_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h status %h",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", 32'(exp_r.status), 32'(m_tuser));
        check_field("removed_value", exp_r.removed, m_tdata[31:0]);
        check_field("front_value", exp_r.front, m_tdata[63:32]);
        check_field("back_value", exp_r.back, m_tdata[95:64]);
        check_field("count", 32'(exp_r.count), 32'(m_tdata[96 +: CNT_W]));
        check_field("is_empty", 32'(exp_r.empty), 32'(m_tdata[96 + CNT_W]));
        check_field("zero fill", '0, 32'(m_tdata[MT_W-1:97 + CNT_W]));
      end
    end
  end

  initial begin
    logic [VALUE_W-1:0] corner_vals [4];
    logic [VALUE_W-1:0] val;
    action_t            act;
    int                 push_pct;
    int                 drain;
    corner_vals = '{32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) begin
      for (int k = 0; k < dir_table[i].reps; k++) begin
        send_req(dir_table[i].act, dir_table[i].val + k, dir_table[i].fixed,
                 dir_table[i].res);
      end
    end

    push_pct = 50;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 79; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 79; end
        default: begin src_idle_pct = 32; snk_stall_pct = 32; end
      endcase
      // back up the block with a long receiver hold-off
      if (p == 4) hold_seq <= hold_seq + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // drift between filling, draining and balanced traffic
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0: push_pct = 15;
            1: push_pct = 50;
            default: push_pct = 85;
          endcase
        end
        if ($urandom_range(99) < push_pct)
          act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        else
          act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
        val = ($urandom_range(7) == 0) ? corner_vals[$urandom_range(3)] : $urandom;
        send_req(act, val, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    drain = 0;
    while (pending_results.size() > 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (pending_results.size() > 0) begin
      $display("%0t: missing results, expected %0d more, actual 0", $time,
               pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
